FILE: design/multi_channel_soft_timer_defines.svh
// Assertion macros used by the checker of the timer block.
`ifndef MULTI_CHANNEL_SOFT_TIMER_DEFINES_SVH
`define MULTI_CHANNEL_SOFT_TIMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MCST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define MCST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/mcst_pkg.sv
package mcst_pkg;

  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_ENABLE = 3'd1;
  localparam logic [2:0] ACT_SET    = 3'd2;
  localparam logic [2:0] ACT_READ   = 3'd3;
  localparam logic [2:0] ACT_TICK   = 3'd4;

  localparam logic [2:0] KIND_ACK     = 3'd0;
  localparam logic [2:0] KIND_ADDED   = 3'd1;
  localparam logic [2:0] KIND_FULL    = 3'd2;
  localparam logic [2:0] KIND_COUNT   = 3'd3;
  localparam logic [2:0] KIND_EXPIRED = 3'd4;

  localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
  localparam int          MAX_REPORT = 8;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_ENABLE,
    OP_SET,
    OP_READ,
    OP_TICK,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  channel;
    logic [31:0] value;
    logic        flag;
    logic [14:0] phase;
  } cmd_t;

endpackage

FILE: design/mcst_front.sv
module mcst_front import mcst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [2:0]  channel,
  input  logic [31:0] value,
  input  logic        enable_flag,
  input  logic        has_callback,
  input  logic [14:0] phase,
  input  logic        q_ready,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic cmd_valid;
  cmd_t cmd;
  cmd_t decoded;
  logic take;

  always_comb begin
    decoded.channel = channel;
    decoded.value   = value;
    decoded.phase   = phase;
    decoded.flag    = 1'b0;
    case (action)
      ACT_ADD: begin
        decoded.op   = OP_ADD;
        decoded.flag = has_callback;
      end
      ACT_ENABLE: begin
        decoded.op   = OP_ENABLE;
        decoded.flag = enable_flag;
      end
      ACT_SET:  decoded.op = OP_SET;
      ACT_READ: decoded.op = OP_READ;
      ACT_TICK: decoded.op = OP_TICK;
      default:  decoded.op = OP_NOP;
    endcase
  end

  assign in_stall = cmd_valid && !q_ready;
  assign take     = in_valid && !in_stall;
  assign q_push   = cmd_valid && q_ready;
  assign q_cmd    = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= take || (cmd_valid && !q_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= decoded;
    end
  end

endmodule

FILE: design/mcst_queue.sv
module mcst_queue import mcst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic ready,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign ready      = (fill != 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: design/mcst_back.sv
module mcst_back import mcst_pkg::*; #(
  parameter int CHANNELS    = 8,
  parameter int BASE_PERIOD = 32768,
  parameter int TICK_SCALE  = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [2:0]  result_channel,
  output logic [31:0] result_value,
  output logic        last
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int UW = $clog2(CHANNELS + 1);
  localparam int VW = (UW > 3) ? UW : 3;
  localparam int DW = 17;
  localparam int PW = DW + 32;
  localparam logic [31:0]   RECIP = 32'(64'hFFFF_FFFF / TICK_SCALE);
  localparam logic [DW-1:0] SCALE = DW'(TICK_SCALE);
  localparam logic [DW-1:0] BASE  = DW'(BASE_PERIOD);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EMIT    = 4'd1;
  localparam logic [3:0] S_RD_WAIT = 4'd2;
  localparam logic [3:0] S_DIV0    = 4'd3;
  localparam logic [3:0] S_DIV1    = 4'd4;
  localparam logic [3:0] S_DIV2    = 4'd5;
  localparam logic [3:0] S_DIV3    = 4'd6;
  localparam logic [3:0] S_RD_UPD  = 4'd7;
  localparam logic [3:0] S_OV_NEXT = 4'd8;
  localparam logic [3:0] S_OV_UPD  = 4'd9;

  logic [3:0]          state;
  logic [3:0]          ret_state;
  cmd_t                cmd;
  logic [CW-1:0]       addr;
  logic [UW-1:0]       idx;
  logic [UW-1:0]       used;
  logic [CHANNELS-1:0] enabled;
  logic [3:0]          nrep;
  logic                pend;
  logic [2:0]          pend_ch;
  logic [DW-1:0]       dvd;
  logic [PW-1:0]       prod1;
  logic [DW-1:0]       q0;
  logic [DW-1:0]       prod2;
  logic [DW-1:0]       quot;
  logic [2:0]          res_kind;
  logic [2:0]          res_ch;
  logic [31:0]         res_value;
  logic                res_last;

  logic [31:0] cnt_mem [CHANNELS];
  logic [14:0] off_mem [CHANNELS];
  logic [31:0] per_mem [CHANNELS];
  logic        ntf_mem [CHANNELS];
  logic [31:0] rd_cnt;
  logic [14:0] rd_off;
  logic [31:0] rd_per;
  logic        rd_ntf;

  logic          cnt_we;
  logic          off_we;
  logic          cfg_we;
  logic [CW-1:0] wr_addr;
  logic [31:0]   wr_cnt;
  logic [14:0]   wr_off;

  logic          full;
  logic          ch_ok;
  logic          ch_live;
  logic [CW-1:0] ch_addr;
  logic [32:0]   sum;
  logic [31:0]   sum_sat;
  logic          at_max;
  logic [31:0]   tick_cnt;
  logic [14:0]   tick_off;
  logic          expire;
  logic          report;
  logic [DW-1:0] rem;

  assign full    = (used == UW'(CHANNELS));
  assign ch_addr = CW'(q_cmd.channel);
  assign ch_ok   = (VW'(q_cmd.channel) < VW'(used));
  assign ch_live = ch_ok && enabled[ch_addr];
  assign q_pop   = (state == S_IDLE) && q_valid;

  assign sum      = {1'b0, rd_cnt} + {16'd0, quot};
  assign sum_sat  = sum[32] ? COUNT_MAX : sum[31:0];
  assign at_max   = (rd_cnt == COUNT_MAX);
  assign tick_cnt = at_max ? rd_cnt : sum_sat;
  assign tick_off = at_max ? rd_off : 15'd0;
  assign expire   = (rd_per != 32'd0) && rd_ntf && (tick_cnt >= rd_per);
  assign report   = expire && (nrep < 4'(MAX_REPORT));
  assign rem      = dvd - prod2;

  always_comb begin
    cnt_we  = 1'b0;
    off_we  = 1'b0;
    cfg_we  = 1'b0;
    wr_addr = addr;
    wr_cnt  = 32'd0;
    wr_off  = 15'd0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_ADD: begin
              if (!full) begin
                cnt_we  = 1'b1;
                off_we  = 1'b1;
                cfg_we  = 1'b1;
                wr_addr = used[CW-1:0];
                wr_off  = q_cmd.phase;
              end
            end
            OP_SET: begin
              if (ch_live) begin
                cnt_we  = 1'b1;
                off_we  = 1'b1;
                wr_addr = ch_addr;
                wr_cnt  = q_cmd.value;
                wr_off  = q_cmd.phase;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_UPD: begin
        cnt_we = 1'b1;
        off_we = 1'b1;
        wr_cnt = sum_sat;
        wr_off = cmd.phase;
      end
      S_OV_UPD: begin
        cnt_we = 1'b1;
        off_we = 1'b1;
        wr_cnt = expire ? 32'd0 : tick_cnt;
        wr_off = expire ? 15'd0 : tick_off;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
    rd_cnt <= cnt_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[wr_addr] <= wr_off;
    end
    rd_off <= off_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      per_mem[wr_addr] <= q_cmd.value;
      ntf_mem[wr_addr] <= q_cmd.flag;
    end
    rd_per <= per_mem[addr];
    rd_ntf <= ntf_mem[addr];
  end

  always_ff @(posedge clk) begin
    case (state)
      S_DIV0: begin
        if (cmd.op == OP_TICK) begin
          dvd <= ({2'b00, rd_off} < BASE) ? BASE - {2'b00, rd_off} : '0;
        end else begin
          dvd <= (cmd.phase > rd_off) ? {2'b00, cmd.phase - rd_off} : '0;
        end
      end
      S_DIV1: prod1 <= {{(PW-DW){1'b0}}, dvd} * {{(PW-32){1'b0}}, RECIP};
      S_DIV2: begin
        q0    <= prod1[PW-1:32];
        prod2 <= DW'(prod1[PW-1:32] * SCALE);
      end
      S_DIV3: quot <= (rem >= SCALE) ? q0 + DW'(1) : q0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      used      <= '0;
      enabled   <= '0;
      nrep      <= 4'd0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd       <= q_cmd;
            res_value <= 32'd0;
            res_last  <= 1'b1;
            ret_state <= S_IDLE;
            case (q_cmd.op)
              OP_ADD: begin
                state <= S_EMIT;
                if (!full) begin
                  enabled[used[CW-1:0]] <= 1'b1;
                  used     <= used + UW'(1);
                  res_kind <= KIND_ADDED;
                  res_ch   <= 3'(used);
                end else begin
                  res_kind <= KIND_FULL;
                  res_ch   <= 3'd0;
                end
              end
              OP_ENABLE: begin
                state    <= S_EMIT;
                res_kind <= KIND_ACK;
                res_ch   <= 3'd0;
                if (ch_ok) begin
                  enabled[ch_addr] <= q_cmd.flag;
                end
              end
              OP_READ: begin
                res_kind <= KIND_COUNT;
                res_ch   <= 3'd0;
                if (ch_live) begin
                  addr  <= ch_addr;
                  state <= S_RD_WAIT;
                end else begin
                  state <= S_EMIT;
                end
              end
              OP_TICK: begin
                res_kind <= KIND_ACK;
                res_ch   <= 3'd0;
                idx      <= '0;
                nrep     <= 4'd0;
                pend     <= 1'b0;
                state    <= S_OV_NEXT;
              end
              default: begin
                state    <= S_EMIT;
                res_kind <= KIND_ACK;
                res_ch   <= 3'd0;
              end
            endcase
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            kind           <= res_kind;
            result_channel <= res_ch;
            result_value   <= res_value;
            last           <= res_last;
            state          <= ret_state;
          end
        end
        S_RD_WAIT: state <= S_DIV0;
        S_DIV0:    state <= S_DIV1;
        S_DIV1:    state <= S_DIV2;
        S_DIV2:    state <= S_DIV3;
        S_DIV3:    state <= (cmd.op == OP_TICK) ? S_OV_UPD : S_RD_UPD;
        S_RD_UPD: begin
          res_kind  <= KIND_COUNT;
          res_ch    <= 3'd0;
          res_value <= sum_sat;
          res_last  <= 1'b1;
          ret_state <= S_IDLE;
          state     <= S_EMIT;
        end
        S_OV_NEXT: begin
          if (idx == UW'(CHANNELS)) begin
            res_kind  <= pend ? KIND_EXPIRED : KIND_ACK;
            res_ch    <= pend ? pend_ch : 3'd0;
            res_value <= 32'd0;
            res_last  <= 1'b1;
            ret_state <= S_IDLE;
            state     <= S_EMIT;
          end else if (enabled[idx[CW-1:0]]) begin
            addr  <= idx[CW-1:0];
            state <= S_RD_WAIT;
          end else begin
            idx <= idx + UW'(1);
          end
        end
        S_OV_UPD: begin
          idx   <= idx + UW'(1);
          state <= (report && pend) ? S_EMIT : S_OV_NEXT;
          if (report) begin
            nrep    <= nrep + 4'd1;
            pend    <= 1'b1;
            pend_ch <= 3'(idx);
            if (pend) begin
              res_kind  <= KIND_EXPIRED;
              res_ch    <= pend_ch;
              res_value <= 32'd0;
              res_last  <= 1'b0;
              ret_state <= S_OV_NEXT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/multi_channel_soft_timer.sv
// Add, enable, set count and unused codes: one result after the front register and queue.
// Read count: the result follows the table read and the divide-by-scale stages.
// Overflow: each enabled channel passes the table read and divide stages, disabled ones are
// skipped, and each expiry result after the first is sent during the walk.
// Requests are taken one at a time by the back end; a 2-entry queue buffers the front.
// Synchronous reset frees the channel table (no channel claimed or enabled); stored counts stay.
module multi_channel_soft_timer import mcst_pkg::*; #(
  parameter int CHANNELS    = 8,
  parameter int BASE_PERIOD = 32768,
  parameter int TICK_SCALE  = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [2:0]  channel,
  input  logic [31:0] value,
  input  logic        enable_flag,
  input  logic        has_callback,
  input  logic [14:0] phase,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [2:0]  result_channel,
  output logic [31:0] result_value,
  output logic        last
);

  logic q_ready;
  logic q_push;
  cmd_t q_in;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  mcst_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .channel      (channel),
    .value        (value),
    .enable_flag  (enable_flag),
    .has_callback (has_callback),
    .phase        (phase),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_cmd        (q_in)
  );

  mcst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_in),
    .ready      (q_ready),
    .head_valid (q_valid),
    .head_cmd   (q_head),
    .pop        (q_pop)
  );

  mcst_back #(
    .CHANNELS    (CHANNELS),
    .BASE_PERIOD (BASE_PERIOD),
    .TICK_SCALE  (TICK_SCALE)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_cmd          (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .result_channel (result_channel),
    .result_value   (result_value),
    .last           (last)
  );

endmodule

FILE: design/mcst_checker.sv
`include "multi_channel_soft_timer_defines.svh"

module mcst_checker import mcst_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  kind,
  input logic [2:0]  result_channel,
  input logic [31:0] result_value,
  input logic        last
);

  `MCST_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(result_channel) && $stable(result_value) && $stable(last), "stalled result changed")
  `MCST_ASSERT_NOW(a_value_zero, out_valid && (kind != KIND_COUNT), result_value == 32'd0, "value set on non-count result")
  `MCST_ASSERT_NOW(a_single_last, out_valid && (kind != KIND_EXPIRED), last, "single result not marked last")
  `MCST_ASSERT_NOW(a_channel_zero, out_valid && (kind == KIND_ACK || kind == KIND_FULL || kind == KIND_COUNT), result_channel == 3'd0, "channel set on result without channel")

endmodule

bind multi_channel_soft_timer mcst_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .kind           (kind),
  .result_channel (result_channel),
  .result_value   (result_value),
  .last           (last)
);
